// File: design/srfd_pkg.sv
// Package: payload types, phase codes and constants for the sprite run frame decoder.
package srfd_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  palette_index;
        logic [15:0] palette_color;
        logic [7:0]  stream_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pixel_color;
    } out_word_t;

    localparam logic [1:0] KIND_SIZE  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [31:0] END_WORD = 32'h7fff7fff;
    localparam logic [9:0]  OFS_BIAS = 10'h200;

    // divider request/response between the parser and the divide unit
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;   // signed linear index
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;       // floor quotient, two's complement row
        logic [16:0] rem;
    } div_rsp_t;

endpackage

// File: design/srfd_div.sv
// Iterative floor divider: signed 48-bit index by unsigned 16-bit width, one bit per cycle.
module srfd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  srfd_pkg::div_req_t req,
    output srfd_pkg::div_rsp_t rsp
);
    import srfd_pkg::*;

    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic        fix_reg, fix_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [47:0] mag;
    logic [47:0] qneg;

    always_comb
    begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        mag       = req.dividend[47] ? (~req.dividend + 48'd1) : req.dividend;
        trial     = {r_reg[15:0], q_reg[47]};
        qneg      = ~q_reg + 48'd1;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.dividend[47];
            cnt_next  = 6'd0;
            q_next    = mag;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[46:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            // convert truncated magnitude result to floor
            if (neg_reg)
            begin
                if (r_reg != '0)
                begin
                    q_next = qneg - 48'd1;
                    r_next = {1'b0, d_reg} - r_reg;
                end
                else
                begin
                    q_next = qneg;
                end
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg[31:0];
    assign rsp.rem  = r_reg;

endmodule

// File: design/srfd_palette.sv
// Palette memory: 256 x 16, one write port, one registered read port.
module srfd_palette (
    input  logic        clk,
    input  logic        we,
    input  logic [7:0]  waddr,
    input  logic [15:0] wdata,
    input  logic [7:0]  raddr,
    output logic [15:0] rdata
);
    logic [15:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/sprite_run_frame_decoder_top.sv
// Top level: byte parser, palette memory and run-position divider.
// Palette load, header and run-word bytes: back to back; a result word is valid the next cycle.
// Pixel byte: palette read registered, then ST_PIX loads its word (in-frame pixels only).
// Last byte of a run word: ST_DIV, then ST_WAIT on the 48-step bit-serial divider and fix-up.
// A waiting output word holds off the input only while out_ready is low.
// Reset clears parse state asynchronously; palette contents are undefined until written.
module sprite_run_frame_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srfd_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srfd_pkg::out_word_t  out_data
);
    import srfd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PIX  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_RUNWORD = 2'd1;
    localparam logic [1:0] PH_PIXELS  = 2'd2;

    state_t      state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [31:0] asm_reg, asm_next;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0] w_reg, w_next, h_reg, h_next;
    logic [11:0] left_reg, left_next;
    logic [16:0] col_reg, col_next;
    logic [31:0] row_reg, row_next;
    logic        ov_reg, ov_next;
    out_word_t   od_reg, od_next;
    logic        ins_reg, ins_next;
    logic [15:0] px_reg, px_next, py_reg, py_next;

    logic [15:0] pal_rdata;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        acc;
    logic [31:0] asm_new;
    logic [2:0]  bcnt_new;
    logic [47:0] lin;
    logic [47:0] xbase;
    logic [18:0] ybase;
    logic signed [35:0] prod;
    logic [9:0]  xo, yo;
    logic [16:0] col_inc;

    srfd_palette u_pal (
        .clk  (clk),
        .we   (acc && !in_data.req_type),
        .waddr(in_data.palette_index),
        .wdata(in_data.palette_color),
        .raddr(in_data.stream_byte),
        .rdata(pal_rdata)
    );

    srfd_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    assign in_ready  = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    assign asm_new  = {in_data.stream_byte, asm_reg[31:8]};
    assign bcnt_new = bcnt_reg + 3'd1;
    assign xo       = asm_new[31:22] ^ OFS_BIAS;
    assign yo       = asm_new[21:12] ^ OFS_BIAS;
    // linear index of the run start; row base fits 19 signed bits, width 16 unsigned
    assign xbase = {{32{cx_reg[15]}}, cx_reg} - 48'h200 + {38'd0, xo};
    assign ybase = {{3{cy_reg[15]}}, cy_reg} + {3'd0, h_reg} - 19'h200 + {9'd0, yo};
    assign prod  = $signed(ybase) * $signed({1'b0, w_reg});
    assign lin   = xbase + {{12{prod[35]}}, prod};
    assign col_inc = col_reg + 17'd1;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bcnt_next  = bcnt_reg;
        asm_next   = asm_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        left_next  = left_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ins_next   = ins_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        dreq.start    = 1'b0;
        dreq.dividend = lin;
        dreq.divisor  = w_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_data.req_type)
                begin
                    if (phase_reg == PH_PIXELS)
                    begin
                        ins_next = !row_reg[31] && (row_reg < {16'd0, h_reg});
                        px_next  = col_reg[15:0];
                        py_next  = row_reg[15:0];
                        if (col_inc >= {1'b0, w_reg})
                        begin
                            col_next = '0;
                            row_next = row_reg + 32'd1;
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                        left_next = left_reg - 12'd1;
                        if (left_reg == 12'd1)
                        begin
                            phase_next = PH_RUNWORD;
                        end
                        state_next = ST_PIX;
                    end
                    else
                    begin
                        asm_next  = asm_new;
                        bcnt_next = bcnt_new;
                        if (phase_reg == PH_RUNWORD)
                        begin
                            if (bcnt_new[1:0] == 2'd0)
                            begin
                                bcnt_next = '0;
                                if (asm_new == END_WORD)
                                begin
                                    phase_next = PH_HEADER;
                                    ov_next    = 1'b1;
                                    od_next    = '{KIND_DONE, 16'd0, 16'd0, 16'd0};
                                end
                                else
                                begin
                                    left_next  = asm_new[11:0];
                                    dreq.start = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            if (bcnt_new == 3'd4)
                            begin
                                cx_next = asm_new[15:0];
                                cy_next = asm_new[31:16];
                            end
                            else if (bcnt_new == 3'd0)
                            begin
                                w_next  = asm_new[15:0];
                                h_next  = asm_new[31:16];
                                ov_next = 1'b1;
                                if (asm_new[15:0] == '0 || asm_new[31:16] == '0)
                                begin
                                    od_next = '{KIND_EMPTY, 16'd0, 16'd0, 16'd0};
                                end
                                else
                                begin
                                    phase_next = PH_RUNWORD;
                                    od_next = '{KIND_SIZE, asm_new[15:0], asm_new[31:16], 16'd0};
                                end
                            end
                        end
                    end
                end
            end
            ST_PIX:
            begin
                if (ins_reg)
                begin
                    ov_next = 1'b1;
                    od_next = '{KIND_PIXEL, px_reg, py_reg, pal_rdata};
                end
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    row_next   = drsp.quot;
                    col_next   = drsp.rem;
                    phase_next = (left_reg != '0) ? PH_PIXELS : PH_RUNWORD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HEADER;
            bcnt_reg  <= '0;
            asm_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            left_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            asm_reg   <= asm_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            left_reg  <= left_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg  <= od_next;
        ins_reg <= ins_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
    end

endmodule
